// File: rtl/core/per_bank_activation_hot_tracker_assert.svh
// Assertion macros shared by the activation tracker RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef PER_BANK_ACTIVATION_HOT_TRACKER_ASSERT_SVH
`define PER_BANK_ACTIVATION_HOT_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PBAHT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBAHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pbaht_pkg.sv
// Package for the per-bank activation hot tracker.
// Holds word types, register indexes and default sizes; no dependencies.
`timescale 1ns / 1ps

package pbaht_pkg;

  // Default sizing of the bank counter store.
  localparam int DEF_MAX_RANKS           = 4;
  localparam int DEF_MAX_GROUPS          = 8;
  localparam int DEF_MAX_BANKS_PER_GROUP = 4;
  localparam int DEF_COUNTER_WIDTH       = 32;

  // Width used for the global bank index and the bank count.
  localparam int GIDX_W = 13;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HOT_THRESHOLD = 3'd0,
    CFG_RANKS         = 3'd1,
    CFG_GROUPS        = 3'd2,
    CFG_BANKS         = 3'd3
  } cfg_reg_t;

  // One issued command.
  typedef struct packed {
    logic       request_valid;
    logic       opens_row;
    logic       is_row_scope;
    logic [1:0] rank_index;
    logic [2:0] group_index;
    logic [1:0] bank_index;
  } req_word_t;

  // One tracker result.
  typedef struct packed {
    logic        counted;
    logic [31:0] total_opens;
    logic [31:0] bank_opens;
    logic        new_hot_event;
    logic        bank_is_hot;
    logic [7:0]  hot_event_total;
  } rsp_word_t;

endpackage

// File: rtl/core/pbaht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read returns the old contents on a same-address write.
`timescale 1ns / 1ps

module pbaht_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/per_bank_activation_hot_tracker.sv
// Per-bank row activation tracker: an accepted word passes the counter RAM read, the update
// stage behind it and the result register; one word per cycle is sustained while the result
// side does not stall. Reset (rst, synchronous) clears the per-entry valid bits and totals and
// sets the configuration to its defaults at once, so no clearing pass runs. A configuration
// write applies to every word accepted after it.
`timescale 1ns / 1ps
`include "per_bank_activation_hot_tracker_assert.svh"

module per_bank_activation_hot_tracker #(
  parameter int MAX_RANKS           = pbaht_pkg::DEF_MAX_RANKS,
  parameter int MAX_GROUPS          = pbaht_pkg::DEF_MAX_GROUPS,
  parameter int MAX_BANKS_PER_GROUP = pbaht_pkg::DEF_MAX_BANKS_PER_GROUP,
  parameter int COUNTER_WIDTH       = pbaht_pkg::DEF_COUNTER_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pbaht_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pbaht_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  pbaht_pkg::req_word_t                req_word,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output pbaht_pkg::rsp_word_t                rsp_word
);

  import pbaht_pkg::*;

  localparam int DEPTH  = MAX_RANKS * MAX_GROUPS * MAX_BANKS_PER_GROUP;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = COUNTER_WIDTH;
  localparam int WORD_W = CW + 1;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  // Configuration registers and derived bank geometry.
  logic [31:0]       hot_threshold;
  logic [2:0]        ranks_in_use;
  logic [3:0]        groups_in_use;
  logic [2:0]        banks_per_group_in_use;
  logic [6:0]        per_rank;
  logic [GIDX_W-1:0] bank_count;

  // Update stage, bypass and totals.
  logic              s1_valid;
  logic              s1_act;
  logic              s1_in_range;
  logic [ADDR_W-1:0] s1_idx;
  logic              byp_hit;
  logic [WORD_W-1:0] byp_data;
  logic [DEPTH-1:0]  entry_valid;
  logic [CW-1:0]     open_total;
  logic [CW-1:0]     open_total_next;
  logic [7:0]        hot_total;
  logic [7:0]        hot_total_next;

  logic              s1_go;
  logic              req_accept;
  logic [GIDX_W-1:0] req_gidx;
  logic              req_in_range;
  logic [ADDR_W-1:0] req_idx;
  logic              req_act;

  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_we;
  logic [WORD_W-1:0] entry;
  logic [CW-1:0]     cnt_new;
  logic              thr_hit;
  logic              hot_new;
  logic [63:0]       cnt_ext;
  logic [63:0]       total_ext;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      hot_threshold          <= '0;
      ranks_in_use           <= 3'd4;
      groups_in_use          <= 4'd8;
      banks_per_group_in_use <= 3'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HOT_THRESHOLD: hot_threshold          <= cfg_data[31:0];
        CFG_RANKS:         ranks_in_use           <= cfg_data[2:0];
        CFG_GROUPS:        groups_in_use          <= cfg_data[3:0];
        CFG_BANKS:         banks_per_group_in_use <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Bank geometry follows the registers directly, so a write reaches the next word.
  always_comb begin
    per_rank   = 7'(groups_in_use * banks_per_group_in_use);
    bank_count = GIDX_W'(ranks_in_use) * GIDX_W'(per_rank);
  end

  // Handshake and global bank index of the incoming word.
  assign s1_go      = !rsp_valid || !rsp_stall;
  assign req_stall  = s1_valid && !s1_go;
  assign req_accept = req_valid && !req_stall;
  assign req_act    = req_word.request_valid && req_word.opens_row && req_word.is_row_scope;
  assign req_gidx   = GIDX_W'(req_word.rank_index) * GIDX_W'(per_rank)
                    + GIDX_W'(req_word.group_index) * GIDX_W'(banks_per_group_in_use)
                    + GIDX_W'(req_word.bank_index);
  assign req_in_range = (req_gidx < bank_count) && (req_gidx < GIDX_W'(DEPTH));
  assign req_idx      = req_gidx[ADDR_W-1:0];

  // Counter store: {hot flag, count} per bank.
  pbaht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_idx),
    .wdata(ram_wdata),
    .re   (req_accept),
    .raddr(req_idx),
    .rdata(ram_rdata)
  );

  // Update stage: pick the current entry, forwarding a write that raced the read.
  always_comb begin
    if (byp_hit) begin
      entry = byp_data;
    end else if (entry_valid[s1_idx]) begin
      entry = ram_rdata;
    end else begin
      entry = '0;
    end
    cnt_new   = (entry[CW-1:0] == CNT_MAX) ? CNT_MAX : entry[CW-1:0] + 1'b1;
    thr_hit   = (hot_threshold != '0) && !entry[CW] && (64'(cnt_new) >= 64'(hot_threshold));
    hot_new   = entry[CW] || thr_hit;
    ram_wdata = {hot_new, cnt_new};
    ram_we    = s1_valid && s1_go && s1_act && s1_in_range;

    open_total_next = open_total;
    if (s1_act && open_total != CNT_MAX) begin
      open_total_next = open_total + 1'b1;
    end
    hot_total_next = hot_total;
    if (s1_act && s1_in_range && thr_hit && hot_total != 8'hFF) begin
      hot_total_next = hot_total + 8'd1;
    end
    cnt_ext   = 64'(cnt_new);
    total_ext = 64'(open_total_next);
  end

  // Stage registers, bypass capture and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      entry_valid <= '0;
      open_total  <= '0;
      hot_total   <= '0;
    end else begin
      s1_valid <= req_accept || (s1_valid && !s1_go);
      if (ram_we) begin
        entry_valid[s1_idx] <= 1'b1;
      end
      if (s1_valid && s1_go) begin
        open_total <= open_total_next;
        hot_total  <= hot_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_act      <= req_act;
      s1_in_range <= req_in_range;
      s1_idx      <= req_idx;
      byp_hit     <= ram_we && (req_idx == s1_idx);
      byp_data    <= ram_wdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= (s1_valid && s1_go) || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go) begin
      rsp_word.counted         <= s1_act && s1_in_range;
      rsp_word.total_opens     <= total_ext[31:0];
      rsp_word.bank_opens      <= (s1_act && s1_in_range) ? cnt_ext[31:0] : 32'd0;
      rsp_word.new_hot_event   <= s1_act && s1_in_range && thr_hit;
      rsp_word.bank_is_hot     <= s1_act && s1_in_range && hot_new;
      rsp_word.hot_event_total <= hot_total_next;
    end
  end

  // Checks on the update logic.
  `PBAHT_ASSERT_IMPLIES(a_hot_event_marks_bank, rsp_valid && rsp_word.new_hot_event, rsp_word.bank_is_hot && rsp_word.counted, "hot event without counted hot bank")
  `PBAHT_ASSERT_IMPLIES(a_uncounted_is_clear, rsp_valid && !rsp_word.counted, rsp_word.bank_opens == 32'd0 && !rsp_word.bank_is_hot && !rsp_word.new_hot_event, "uncounted word carries bank data")
  `PBAHT_ASSERT_IMPLIES(a_write_on_advance, ram_we, s1_valid && s1_go && s1_in_range, "store written without an advancing counted word")
  `PBAHT_ASSERT_NEXT(a_hot_total_grows, 1'b1, hot_total >= $past(hot_total), "hot event total decreased")

endmodule

// File: tb/pbaht_activation_checker.sv
// Checker for the per-bank activation hot tracker: predicts every result word and compares it.
// Depends on pbaht_pkg for the word types and register indexes.
`timescale 1ns / 1ps

module pbaht_activation_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pbaht_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbaht_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              req_valid,
  input  logic                              req_stall,
  input  pbaht_pkg::req_word_t              req_word,
  input  logic                              rsp_valid,
  input  logic                              rsp_stall,
  input  pbaht_pkg::rsp_word_t              rsp_word,
  output int                                failures,
  output int                                pending
);
  import pbaht_pkg::*;

  localparam int BANK_SLOTS = DEF_MAX_RANKS * DEF_MAX_GROUPS * DEF_MAX_BANKS_PER_GROUP;

  // Shadow copy of the configuration registers.
  logic [31:0] hot_limit;
  logic [2:0]  ranks_cfg;
  logic [3:0]  groups_cfg;
  logic [2:0]  banks_cfg;

  // Shadow copy of the tracker state.
  logic [31:0] opens_per_bank [BANK_SLOTS];
  bit          hot_mark [BANK_SLOTS];
  logic [31:0] open_count;
  logic [7:0]  hot_events;

  // Result words still owed by the tracker, oldest first.
  rsp_word_t   owed_results [$];
  rsp_word_t   want;

  // Applies one command word to the shadow state and returns the result word it causes.
  function automatic rsp_word_t tally_activation(req_word_t w);
    rsp_word_t   r;
    int unsigned per_rank;
    int unsigned bank_count;
    int unsigned slot;
    r = '0;
    if (w.request_valid && w.opens_row && w.is_row_scope) begin
      per_rank   = groups_cfg * banks_cfg;
      bank_count = ranks_cfg * per_rank;
      slot       = w.rank_index * per_rank + w.group_index * banks_cfg + w.bank_index;
      if (open_count != '1) open_count = open_count + 32'd1;
      // Only banks inside both the configured geometry and the store are counted.
      if (slot < bank_count && slot < BANK_SLOTS) begin
        if (opens_per_bank[slot] != '1) opens_per_bank[slot] = opens_per_bank[slot] + 32'd1;
        if (hot_limit != 0 && !hot_mark[slot] && opens_per_bank[slot] >= hot_limit) begin
          hot_mark[slot] = 1'b1;
          if (hot_events != 8'hFF) hot_events = hot_events + 8'd1;
          r.new_hot_event = 1'b1;
        end
        r.counted     = 1'b1;
        r.bank_opens  = opens_per_bank[slot];
        r.bank_is_hot = hot_mark[slot];
      end
    end
    r.total_opens     = open_count;
    r.hot_event_total = hot_events;
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(string field, longint unsigned exp_val, longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      failures++;
    end
  endtask

  // Watch both channels and the register port on every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      hot_limit  = 32'd0;
      ranks_cfg  = 3'd4;
      groups_cfg = 4'd8;
      banks_cfg  = 3'd4;
      foreach (opens_per_bank[i]) begin
        opens_per_bank[i] = '0;
        hot_mark[i]       = 1'b0;
      end
      open_count = '0;
      hot_events = '0;
      failures   = 0;
      owed_results.delete();
    end else begin
      // Writes to an unknown index leave every register alone.
      if (cfg_write) begin
        case (cfg_index)
          CFG_HOT_THRESHOLD: hot_limit  = cfg_data;
          CFG_RANKS:         ranks_cfg  = cfg_data[2:0];
          CFG_GROUPS:        groups_cfg = cfg_data[3:0];
          CFG_BANKS:         banks_cfg  = cfg_data[2:0];
          default: ;
        endcase
      end
      // Compare an accepted result word with the oldest prediction.
      if (rsp_valid && !rsp_stall) begin
        if (owed_results.size() == 0) begin
          $error("result word arrived with no command word outstanding");
          failures++;
        end else begin
          want = owed_results.pop_front();
          check_field("counted", want.counted, rsp_word.counted);
          check_field("total_opens", want.total_opens, rsp_word.total_opens);
          check_field("bank_opens", want.bank_opens, rsp_word.bank_opens);
          check_field("new_hot_event", want.new_hot_event, rsp_word.new_hot_event);
          check_field("bank_is_hot", want.bank_is_hot, rsp_word.bank_is_hot);
          check_field("hot_event_total", want.hot_event_total, rsp_word.hot_event_total);
        end
      end
      // Every accepted command word owes exactly one result word.
      if (req_valid && !req_stall) owed_results.push_back(tally_activation(req_word));
    end
    pending <= owed_results.size();
  end

endmodule

// File: tb/per_bank_activation_hot_tracker_test.sv
// Top of the activation tracker testbench: clock, reset, stimulus and the verdict.
// Depends on pbaht_pkg, the tracker RTL and pbaht_activation_checker.
`timescale 1ns / 1ps

module per_bank_activation_hot_tracker_test;
  import pbaht_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_INDEX_W-1:0] UNUSED_REG = 3'd6;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_word_t              req_word  = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_word_t              rsp_word;

  int          failures;
  int          pending;
  int unsigned cycle_count  = 0;
  int          send_gap_pct = 35;
  int          stall_pct    = 59;

  per_bank_activation_hot_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  pbaht_activation_checker tally_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .failures  (failures),
    .pending   (pending)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random, at the rate of the current mode.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Cycle counter and the timeout it guards.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic req_word_t command_word(bit v, bit o, bit r, logic [1:0] rk,
                                             logic [2:0] g, logic [1:0] b);
    req_word_t w;
    w.request_valid = v;
    w.opens_row     = o;
    w.is_row_scope  = r;
    w.rank_index    = rk;
    w.group_index   = g;
    w.bank_index    = b;
    return w;
  endfunction

  // Mostly row activations, with a share aimed at a few banks so they heat up.
  function automatic req_word_t random_word();
    req_word_t   w;
    logic [31:0] raw;
    raw = $urandom;
    w   = raw[$bits(req_word_t)-1:0];
    if ($urandom_range(99) < 75) begin
      w.request_valid = 1'b1;
      w.opens_row     = 1'b1;
      w.is_row_scope  = 1'b1;
    end
    if ($urandom_range(99) < 40) begin
      w.rank_index  = 2'd0;
      w.group_index = 3'($urandom_range(1));
    end
    return w;
  endfunction

  // Offers one command word, after a random gap, and holds it until accepted.
  task automatic send_word(req_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall);
  endtask

  // Stops sending and waits until every owed result word has come back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Rewrites all registers while the tracker is idle, then lets the change settle.
  task automatic apply_setting(logic [31:0] thr, logic [2:0] ranks, logic [3:0] groups,
                               logic [2:0] banks, bit poke_unused);
    drain();
    repeat (2) @(posedge clk);
    write_reg(CFG_HOT_THRESHOLD, thr);
    write_reg(CFG_RANKS, ranks);
    write_reg(CFG_GROUPS, groups);
    write_reg(CFG_BANKS, banks);
    if (poke_unused) write_reg(UNUSED_REG, 32'hFFFF_FFFF);
    cfg_write <= 1'b0;
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry with hot detection off: non-activations and the corner banks.
    send_word(command_word(1'b0, 1'b1, 1'b1, 2'd3, 3'd7, 2'd3));
    send_word(command_word(1'b1, 1'b0, 1'b1, 2'd1, 3'd2, 2'd1));
    send_word(command_word(1'b1, 1'b1, 1'b0, 2'd2, 3'd5, 2'd2));
    send_word(command_word(1'b0, 1'b0, 1'b0, 2'd0, 3'd0, 2'd0));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd0, 3'd0, 2'd0));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd3, 3'd7, 2'd3));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd3, 3'd7, 2'd3));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd2, 3'd4, 2'd1));

    // Smallest geometry, threshold of one: first hit turns hot, a repeat stays hot, the rest is out of range.
    apply_setting(32'd1, 3'd1, 4'd1, 3'd1, 1'b0);
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd0, 3'd0, 2'd0));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd0, 3'd0, 2'd0));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd1, 3'd0, 2'd0));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd0, 3'd1, 2'd0));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd0, 3'd0, 2'd1));

    // Zero registers leave no bank to count.
    apply_setting(32'd2, 3'd0, 4'd8, 3'd0, 1'b0);
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd0, 3'd0, 2'd0));

    // Geometry beyond the store: the store depth bounds the index.
    apply_setting(32'd6, 3'd7, 4'd15, 3'd7, 1'b1);
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd3, 3'd7, 2'd3));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd0, 3'd7, 2'd3));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd1, 3'd0, 2'd0));
    send_word(command_word(1'b1, 1'b1, 1'b1, 2'd1, 3'd3, 2'd2));

    // Random phases over several settings and three idling modes.
    for (int k = 0; k < 9; k++) begin
      if (k == 3) begin
        send_gap_pct = 59;
        stall_pct    = 35;
      end else if (k == 6) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      case (k)
        0: apply_setting(32'd1, 3'd1, 4'd1, 3'd1, 1'b0);
        1: apply_setting(32'hFFFF_FFFF, 3'd4, 4'd8, 3'd4, 1'b0);
        2: apply_setting(32'd0, 3'd4, 4'd0, 3'd4, 1'b0);
        3: apply_setting(32'd6, 3'd7, 4'd15, 3'd7, 1'b1);
        4: apply_setting(32'd3, 3'd2, 4'd5, 3'd3, 1'b0);
        5: apply_setting(32'd2, 3'd3, 4'd2, 3'd4, 1'b0);
        6: apply_setting(32'h8000_0000, 3'd1, 4'd8, 3'd4, 1'b0);
        7: apply_setting(32'd4, 3'd4, 4'd8, 3'd4, 1'b0);
        default: apply_setting(32'd3, 3'd4, 4'd8, 3'd4, 1'b0);
      endcase
      for (int n = 0; n < 60; n++) begin
        // Once, hold off mid-phase until the tracker has returned everything.
        if (k == 4 && n == 30) drain();
        send_word(random_word());
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pbaht_pkg.sv
rtl/core/pbaht_ram.sv
rtl/core/per_bank_activation_hot_tracker.sv
tb/pbaht_activation_checker.sv
tb/per_bank_activation_hot_tracker_test.sv
